>>> design/ntwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwa_pkg: shared types and codes of the neighbour table
// entry layout, result layout, operation codes and the compare unit request
// ----------------------------------------------------------------------------
package ntwa_pkg;

	// operation codes carried on s_tuser
	localparam logic [2:0] MODE_UPDATE    = 3'd0;
	localparam logic [2:0] MODE_LOOKUP    = 3'd1;
	localparam logic [2:0] MODE_LIST_ALL  = 3'd2;
	localparam logic [2:0] MODE_LIST_TYPE = 3'd3;
	localparam logic [2:0] MODE_PURGE     = 3'd4;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned TYPE_W  = 16;
	localparam int unsigned AMT_W   = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 5;

	// one stored slot
	typedef struct packed {
		logic [KEY_W-1:0]         node_key;
		logic [TYPE_W-1:0]        res_type;
		logic signed [AMT_W-1:0]  res_amount;
		logic [TIME_W-1:0]        first_time;
		logic [TIME_W-1:0]        last_time;
	} entry_t;

	// one result before count and last flag are attached
	typedef struct packed {
		logic              found;
		logic              table_full;
		entry_t            ent;
		logic [TIME_W-1:0] duration;
	} res_t;

	// request to the shared compare and subtract unit
	typedef struct packed {
		logic [KEY_W-1:0]  eq_a;
		logic [KEY_W-1:0]  eq_b;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] sub_opnd;
		logic [TIME_W-1:0] max_age;
	} alu_in_t;

	// answer of the shared unit
	typedef struct packed {
		logic              eq;
		logic              stale;
		logic [TIME_W-1:0] diff;
	} alu_out_t;

endpackage : ntwa_pkg
`default_nettype wire

>>> design/ntwa_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwa_alu: shared compare unit
// one equality compare, one modulo subtract and one magnitude compare
// ----------------------------------------------------------------------------
module ntwa_alu (
	input  var ntwa_pkg::alu_in_t  req,
	output var ntwa_pkg::alu_out_t rsp
);

	logic [ntwa_pkg::TIME_W-1:0] diff;

	// time difference wraps modulo 2^32
	assign diff      = req.now - req.sub_opnd;
	assign rsp.diff  = diff;
	assign rsp.eq    = (req.eq_a == req.eq_b);
	assign rsp.stale = (diff > req.max_age);

endmodule : ntwa_alu
`default_nettype wire

>>> design/ntwa_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwa_store: slot memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module ntwa_store #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned IW      = $clog2(ENTRIES)
) (
	input  var logic                   clk,
	input  var logic                   rd_en,
	input  var logic [IW-1:0]          rd_addr,
	output var ntwa_pkg::entry_t       rd_data,
	input  var logic                   wr_en,
	input  var logic [IW-1:0]          wr_addr,
	input  var ntwa_pkg::entry_t       wr_data
);

	ntwa_pkg::entry_t mem_q [ENTRIES];
	ntwa_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule : ntwa_store
`default_nettype wire

>>> design/neighbor_table_with_aging.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_table_with_aging: associative neighbour table with purge by age
// keyed table of ENTRIES slots, scanned one slot at a time through one
// memory read port and one shared compare unit
// ----------------------------------------------------------------------------
// sequence: each slot passes ST_RD and ST_EV on the single memory read port;
//   update then adds ST_WR, unused codes skip the scan, and all end in ST_FIN
//   until the output register is free; a listing scan also holds in ST_EV when a
//   second match meets a full output register; a new request is taken only in ST_IDLE
// reset: valid bits and entry count cleared at once, max_age set to 1000,
//   slot memory is not cleared (no clearing pass, ready right after reset)
// ----------------------------------------------------------------------------
module neighbor_table_with_aging #(
	parameter int unsigned ENTRIES = 16
) (
	input  var logic         clk,
	input  var logic         arst_n,

	// configuration: max_age
	input  var logic         cfg_valid,
	output var logic         cfg_ready,
	input  var logic [31:0]  cfg_data,

	// request side
	input  var logic         s_tvalid,
	output var logic         s_tready,
	// node_key[31:0], res_type[47:32], res_amount[79:48], time_now[111:80]
	input  var logic [111:0] s_tdata,
	// mode[2:0]
	input  var logic [2:0]   s_tuser,

	// result side
	output var logic         m_tvalid,
	input  var logic         m_tready,
	// out_key[31:0], out_type[47:32], out_amount[79:48], out_first[111:80],
	// out_last_heard[143:112], duration[175:144], entry_count[180:176],
	// zero fill[183:181]
	output var logic [183:0] m_tdata,
	// found[0], table_full[1]
	output var logic [1:0]   m_tuser,
	// last_result
	output var logic         m_tlast
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_EV   = 5'b00100,
		ST_WR   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// latched request
	logic [2:0]                          mode_q;
	logic [ntwa_pkg::KEY_W-1:0]          key_q;
	logic [ntwa_pkg::TYPE_W-1:0]         type_q;
	logic signed [ntwa_pkg::AMT_W-1:0]   amount_q;
	logic [ntwa_pkg::TIME_W-1:0]         now_q;

	logic [31:0]         max_age_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [CW-1:0]       count_q;
	logic [IW-1:0]       idx_q;

	// update scan results
	logic                        hit_q;
	logic [IW-1:0]               hit_idx_q;
	logic [ntwa_pkg::TIME_W-1:0] hit_first_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;

	// staged result; pend_q marks a listing match not yet sent
	ntwa_pkg::res_t res_q;
	logic           pend_q;

	// output register
	logic           out_valid_q;
	ntwa_pkg::res_t out_res_q;
	logic [4:0]     out_cnt_q;
	logic           out_last_q;

	ntwa_pkg::entry_t   rd_data;
	ntwa_pkg::entry_t   wr_entry;
	ntwa_pkg::alu_in_t  alu_req;
	ntwa_pkg::alu_out_t alu_rsp;

	logic              in_acc;
	logic              out_free;
	logic              slot_valid;
	logic              is_list;
	logic              list_match;
	logic              stall;
	logic              push_pend;
	logic              fin_load;
	logic              wr_en;
	logic [IW-1:0]     wr_addr;
	logic [CW+4:0]     cnt_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign slot_valid = valid_q[idx_q];
	assign is_list    = (mode_q == ntwa_pkg::MODE_LIST_ALL) ||
	                    (mode_q == ntwa_pkg::MODE_LIST_TYPE);
	assign list_match = is_list && slot_valid &&
	                    ((mode_q == ntwa_pkg::MODE_LIST_ALL) || alu_rsp.eq);
	// a second match can only be staged once the earlier one has left
	assign stall      = (state_q == ST_EV) && list_match && pend_q && !out_free;
	assign push_pend  = (state_q == ST_EV) && list_match && pend_q && out_free;
	assign fin_load   = (state_q == ST_FIN) && out_free;

	// entry written by update: refresh keeps key and first-heard
	always_comb begin
		wr_entry.node_key   = hit_q ? key_q : key_q;
		wr_entry.res_type   = type_q;
		wr_entry.res_amount = amount_q;
		wr_entry.first_time = hit_q ? hit_first_q : now_q;
		wr_entry.last_time  = now_q;
	end

	assign wr_en   = (state_q == ST_WR) && (hit_q || free_q);
	assign wr_addr = hit_q ? hit_idx_q : free_idx_q;

	// operand selection for the shared unit
	always_comb begin
		alu_req.now     = now_q;
		alu_req.max_age = max_age_q;
		if (mode_q == ntwa_pkg::MODE_LIST_TYPE) begin
			alu_req.eq_a = {16'd0, rd_data.res_type};
			alu_req.eq_b = {16'd0, type_q};
		end else begin
			alu_req.eq_a = rd_data.node_key;
			alu_req.eq_b = key_q;
		end
		if (state_q == ST_WR) begin
			alu_req.sub_opnd = wr_entry.first_time;
		end else if (mode_q == ntwa_pkg::MODE_PURGE) begin
			alu_req.sub_opnd = rd_data.last_time;
		end else begin
			alu_req.sub_opnd = rd_data.first_time;
		end
	end

	ntwa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	ntwa_store #(
		.ENTRIES (ENTRIES),
		.IW      (IW)
	) u_store (
		.clk     (clk),
		.rd_en   (state_q == ST_RD),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= 32'd1000;
		end else if (cfg_valid && cfg_ready) begin
			max_age_q <= cfg_data;
		end
	end

	// sequencer: read slot, evaluate slot, then write back or report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						pend_q <= 1'b0;
						// unused codes skip the scan and report only the count
						if (s_tuser == ntwa_pkg::MODE_UPDATE ||
						    s_tuser == ntwa_pkg::MODE_LOOKUP ||
						    s_tuser == ntwa_pkg::MODE_LIST_ALL ||
						    s_tuser == ntwa_pkg::MODE_LIST_TYPE ||
						    s_tuser == ntwa_pkg::MODE_PURGE) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					unique case (mode_q) inside
						ntwa_pkg::MODE_UPDATE: begin
							if (slot_valid && alu_rsp.eq && !hit_q) begin
								hit_q <= 1'b1;
							end
							if (!slot_valid && !free_q) begin
								free_q <= 1'b1;
							end
						end
						ntwa_pkg::MODE_LOOKUP: begin
							if (slot_valid && alu_rsp.eq && !hit_q) begin
								hit_q <= 1'b1;
							end
						end
						ntwa_pkg::MODE_LIST_ALL, ntwa_pkg::MODE_LIST_TYPE: begin
							if (list_match && !stall) begin
								pend_q <= 1'b1;
							end
						end
						ntwa_pkg::MODE_PURGE: begin
							if (slot_valid && alu_rsp.stale) begin
								valid_q[idx_q] <= 1'b0;
								count_q        <= count_q - CW'(1);
							end
						end
						default: begin
						end
					endcase
					if (!stall) begin
						if (idx_q == LAST_IDX) begin
							state_q <= (mode_q == ntwa_pkg::MODE_UPDATE) ? ST_WR : ST_FIN;
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_WR: begin
					// new key takes the lowest free slot
					if (!hit_q && free_q) begin
						valid_q[free_idx_q] <= 1'b1;
						count_q             <= count_q + CW'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and scan payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q   <= s_tuser;
			key_q    <= s_tdata[31:0];
			type_q   <= s_tdata[47:32];
			amount_q <= s_tdata[79:48];
			now_q    <= s_tdata[111:80];
			res_q    <= '0;
		end else begin
			if (state_q == ST_EV) begin
				if (mode_q == ntwa_pkg::MODE_UPDATE) begin
					if (slot_valid && alu_rsp.eq && !hit_q) begin
						hit_idx_q   <= idx_q;
						hit_first_q <= rd_data.first_time;
					end
					if (!slot_valid && !free_q) begin
						free_idx_q <= idx_q;
					end
				end
				if (mode_q == ntwa_pkg::MODE_LOOKUP && slot_valid && alu_rsp.eq && !hit_q) begin
					res_q.found      <= 1'b1;
					res_q.table_full <= 1'b0;
					res_q.ent        <= rd_data;
					res_q.duration   <= alu_rsp.diff;
				end
				if (list_match && !stall) begin
					res_q.found      <= 1'b1;
					res_q.table_full <= 1'b0;
					res_q.ent        <= rd_data;
					res_q.duration   <= alu_rsp.diff;
				end
			end
			if (state_q == ST_WR) begin
				res_q.found      <= hit_q;
				res_q.table_full <= !hit_q && !free_q;
				if (hit_q || free_q) begin
					res_q.ent      <= wr_entry;
					res_q.duration <= alu_rsp.diff;
				end else begin
					res_q.ent      <= '0;
					res_q.duration <= '0;
				end
			end
		end
	end

	// output register: staged result leaves as a middle or final result
	assign cnt_ext = {5'd0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || fin_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend || fin_load) begin
			out_res_q  <= res_q;
			out_cnt_q  <= cnt_ext[4:0];
			out_last_q <= fin_load;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_cnt_q, out_res_q.duration,
	                   out_res_q.ent.last_time, out_res_q.ent.first_time,
	                   out_res_q.ent.res_amount, out_res_q.ent.res_type,
	                   out_res_q.ent.node_key};
	assign m_tuser  = {out_res_q.table_full, out_res_q.found};
	assign m_tlast  = out_last_q;

endmodule : neighbor_table_with_aging
`default_nettype wire
